### rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

   // Store size and word width.
   localparam int CAPACITY   = 32;
   localparam int DATA_WIDTH = 32;

   // Slot indices and the element count.
   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // Widths of the channel fields.
   localparam int CMD_W      = 2;
   localparam int POS_W      = 6;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int ELEMENT_W  = 32;
   localparam int COUNT_FW   = 6;

   // Common width for comparing positions against the count, and for
   // widening words before they are cut to a field.
   localparam int POS_CMP_W  = 8;
   localparam int WIDE_W     = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT,
      CMD_DELETE,
      CMD_DUMP
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_BADPOS,
      STAT_EMPTY,
      STAT_FULL
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_INS_LINK,
      ST_TAIL_FIX,
      ST_DEL_HEAD,
      ST_DEL_NEXT,
      ST_DUMP,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

### rtl/pss_if.sv
`default_nettype none

interface pss_req_if import pss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [POS_W-1:0]   position;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pss_rsp_if import pss_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ELEMENT_W-1:0] element;
   logic [COUNT_FW-1:0]  count;
   logic                 last;

   modport source (output valid, output status, output element, output count, output last,
                   input ready);
   modport sink   (input valid, input status, input element, input count, input last,
                   output ready);
endinterface

`default_nettype wire

### rtl/pss_ram.sv
`default_nettype none

module pss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read data is registered and holds while no read is issued.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/positional_sequence_store_top.sv
// Positional sequence store: an ordered list of up to CAPACITY words kept as a
// circular singly linked list in two single-port-write RAMs (words and next
// links), with head, tail, count and a free-slot mask in flip-flops. A command
// is taken on the req_ channel only while the sequencer is idle; one command
// is worked on at a time. Insert and delete at position p walk p-2 links from
// the head, one link RAM read per cycle. An insert or delete at position 1
// skips the walk; an insert into an empty store, the delete of the only
// element and every rejected command go straight to the result state. A
// dump streams one element per cycle in list order while the receiver keeps
// up, and marks the final transfer with last. Every other command gives
// exactly one transfer on the rsp_ channel, with last set. The next command
// may be accepted in the cycle after the last result of the previous one has
// been loaded. The walk rate is set by the registered read of the link RAM,
// which chains one read into the next. The result sits in an output
// register, so the next command may be accepted while the previous result
// still waits to be taken; a stalled receiver holds the sequencer once that
// next command has a result of its own to load. Freed slots are reused
// lowest index first. The RAMs need no clearing after reset: only slots on
// the list are ever read.

`default_nettype none

module positional_sequence_store_top import pss_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   pss_req_if.sink   req_ch,
   pss_rsp_if.source rsp_ch
);

   // Sequencer and command registers.
   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [STATUS_W-1:0]  stat_ff, stat_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SLOT_W-1:0]    next_ff, next_in;
   logic [COUNT_W-1:0]   hops_ff, hops_in;

   // List state.
   logic [SLOT_W-1:0]    head_ff, head_in;
   logic [SLOT_W-1:0]    tail_ff, tail_in;
   logic [CAPACITY-1:0]  free_ff, free_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ELEMENT_W-1:0] rsp_element_ff, rsp_element_in;
   logic [COUNT_FW-1:0]  rsp_count_ff;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_load;

   // RAM ports.
   logic                  elem_we;
   logic [DATA_WIDTH-1:0] elem_wdata;
   logic [DATA_WIDTH-1:0] elem_rdata;
   logic                  link_we;
   logic [SLOT_W-1:0]     link_waddr;
   logic [SLOT_W-1:0]     link_wdata;
   logic [SLOT_W-1:0]     link_rdata;
   logic                  rd_re;
   logic [SLOT_W-1:0]     rd_addr;

   // Decode of the incoming command against the present count.
   logic                  accept;
   logic                  out_free;
   logic [POS_CMP_W-1:0]  pos_ext;
   logic [POS_CMP_W-1:0]  posff_ext;
   logic [POS_CMP_W-1:0]  cnt_ext;
   logic                  ins_bad;
   logic                  del_bad;
   logic                  is_full;
   logic                  is_empty;
   logic                  pos_one;
   logic [SLOT_W-1:0]     free_slot;
   logic [WIDE_W-1:0]     val_wide;
   logic [WIDE_W-1:0]     elem_wide;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign pos_ext   = POS_CMP_W'(req_ch.position);
   assign posff_ext = POS_CMP_W'(pos_ff);
   assign cnt_ext   = POS_CMP_W'(count_ff);
   assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + POS_CMP_W'(1));
   assign del_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign is_full   = (count_ff == COUNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign pos_one   = (req_ch.position == POS_W'(1));

   assign val_wide   = WIDE_W'(req_ch.value);
   assign elem_wdata = val_wide[DATA_WIDTH-1:0];
   assign elem_wide  = WIDE_W'(elem_rdata);

   // Lowest free slot.
   always_comb begin
      free_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   pss_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .waddr (free_slot),
      .wdata (elem_wdata),
      .re    (rd_re),
      .raddr (rd_addr),
      .rdata (elem_rdata)
   );

   pss_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (rd_re),
      .raddr (rd_addr),
      .rdata (link_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.cmd)
                  CMD_INSERT: begin
                     if (ins_bad || is_full || is_empty) begin
                        state_in = ST_RESP;
                     end else if (pos_one) begin
                        state_in = ST_TAIL_FIX;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_DELETE: begin
                     if (is_empty || del_bad || (head_ff == tail_ff)) begin
                        state_in = ST_RESP;
                     end else if (pos_one) begin
                        state_in = ST_DEL_HEAD;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  CMD_DUMP: begin
                     state_in = is_empty ? ST_RESP : ST_DUMP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (hops_ff == '0) begin
               state_in = (cmd_ff == CMD_INSERT) ? ST_INS_LINK : ST_DEL_NEXT;
            end
         end
         ST_INS_LINK, ST_TAIL_FIX, ST_DEL_HEAD, ST_DEL_NEXT: begin
            state_in = ST_RESP;
         end
         ST_DUMP: begin
            if (out_free && (hops_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM accesses and result loading for each state.
   always_comb begin
      cmd_in         = cmd_ff;
      pos_in         = pos_ff;
      stat_in        = stat_ff;
      cur_in         = cur_ff;
      slot_in        = slot_ff;
      next_in        = next_ff;
      hops_in        = hops_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      free_in        = free_ff;
      count_in       = count_ff;
      elem_we        = 1'b0;
      link_we        = 1'b0;
      link_waddr     = slot_ff;
      link_wdata     = next_ff;
      rd_re          = 1'b0;
      rd_addr        = link_rdata;
      rsp_load       = 1'b0;
      rsp_status_in  = stat_ff;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = req_ch.cmd;
               pos_in  = req_ch.position;
               stat_in = STAT_OK;
               cur_in  = head_ff;
               case (req_ch.cmd)
                  CMD_INSERT: begin
                     if (ins_bad) begin
                        stat_in = STAT_BADPOS;
                     end else if (is_full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        // The word goes straight into a fresh slot.
                        elem_we            = 1'b1;
                        free_in[free_slot] = 1'b0;
                        slot_in            = free_slot;
                        if (is_empty) begin
                           link_we    = 1'b1;
                           link_waddr = free_slot;
                           link_wdata = free_slot;
                           head_in    = free_slot;
                           tail_in    = free_slot;
                           count_in   = count_ff + COUNT_W'(1);
                        end else if (pos_one) begin
                           link_we    = 1'b1;
                           link_waddr = free_slot;
                           link_wdata = head_ff;
                           head_in    = free_slot;
                           count_in   = count_ff + COUNT_W'(1);
                        end else begin
                           rd_re   = 1'b1;
                           rd_addr = head_ff;
                           hops_in = COUNT_W'(req_ch.position) - COUNT_W'(2);
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (is_empty) begin
                        stat_in = STAT_EMPTY;
                     end else if (del_bad) begin
                        stat_in = STAT_BADPOS;
                     end else if (head_ff == tail_ff) begin
                        free_in[head_ff] = 1'b1;
                        head_in          = '0;
                        tail_in          = '0;
                        count_in         = count_ff - COUNT_W'(1);
                     end else if (pos_one) begin
                        rd_re   = 1'b1;
                        rd_addr = head_ff;
                        slot_in = head_ff;
                     end else begin
                        rd_re   = 1'b1;
                        rd_addr = head_ff;
                        hops_in = COUNT_W'(req_ch.position) - COUNT_W'(2);
                     end
                  end
                  CMD_DUMP: begin
                     if (is_empty) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        rd_re   = 1'b1;
                        rd_addr = head_ff;
                        hops_in = count_ff - COUNT_W'(1);
                     end
                  end
                  default: begin
                     stat_in = STAT_BADPOS;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // The link of cur_ff is on the read port; follow it.
            rd_re   = 1'b1;
            rd_addr = link_rdata;
            if (hops_ff != '0) begin
               cur_in  = link_rdata;
               hops_in = hops_ff - COUNT_W'(1);
            end else if (cmd_ff == CMD_INSERT) begin
               // cur_ff is the predecessor: point it at the new slot.
               link_we    = 1'b1;
               link_waddr = cur_ff;
               link_wdata = slot_ff;
               next_in    = link_rdata;
               count_in   = count_ff + COUNT_W'(1);
               if (posff_ext == cnt_ext + POS_CMP_W'(1)) begin
                  tail_in = slot_ff;
               end
            end else begin
               // The victim's own link arrives next cycle.
               slot_in = link_rdata;
            end
         end

         ST_INS_LINK: begin
            link_we    = 1'b1;
            link_waddr = slot_ff;
            link_wdata = next_ff;
         end

         ST_TAIL_FIX: begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = head_ff;
         end

         ST_DEL_HEAD: begin
            head_in          = link_rdata;
            link_we          = 1'b1;
            link_waddr       = tail_ff;
            link_wdata       = link_rdata;
            free_in[slot_ff] = 1'b1;
            count_in         = count_ff - COUNT_W'(1);
         end

         ST_DEL_NEXT: begin
            link_we          = 1'b1;
            link_waddr       = cur_ff;
            link_wdata       = link_rdata;
            free_in[slot_ff] = 1'b1;
            count_in         = count_ff - COUNT_W'(1);
            if (slot_ff == tail_ff) begin
               tail_in = cur_ff;
            end
         end

         ST_DUMP: begin
            // Read data holds while the output is stalled.
            if (out_free) begin
               rsp_load       = 1'b1;
               rsp_status_in  = STAT_OK;
               rsp_element_in = elem_wide[ELEMENT_W-1:0];
               rsp_last_in    = (hops_ff == '0);
               if (hops_ff != '0) begin
                  rd_re   = 1'b1;
                  rd_addr = link_rdata;
                  hops_in = hops_ff - COUNT_W'(1);
               end
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
            end
         end

         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= {CAPACITY{1'b1}};
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      pos_ff  <= pos_in;
      stat_ff <= stat_in;
      cur_ff  <= cur_in;
      slot_ff <= slot_in;
      next_ff <= next_in;
      hops_ff <= hops_in;
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_element_ff <= rsp_element_in;
         rsp_count_ff   <= cnt_ext[COUNT_FW-1:0];
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.element = rsp_element_ff;
   assign rsp_ch.count   = rsp_count_ff;
   assign rsp_ch.last    = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/pss_checker.sv
`default_nettype none

module pss_checker import pss_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic [ELEMENT_W-1:0] rsp_element,
   input wire logic [COUNT_FW-1:0]  rsp_count,
   input wire logic                 rsp_last
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_element)
         && $stable(rsp_count) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Any result that is not a good transfer is a single, final one with no element.
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_last && (rsp_element == '0))
      else $error("error result carries data or is not final");

   // An empty report always shows a count of zero.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_EMPTY) |-> (rsp_count == '0))
      else $error("empty status with non-zero count");

   // A full report always shows the store at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> (rsp_count == COUNT_FW'(CAPACITY)))
      else $error("full status with count below capacity");

endmodule

bind positional_sequence_store_top pss_checker u_pss_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_status  (rsp_ch.status),
   .rsp_element (rsp_ch.element),
   .rsp_count   (rsp_ch.count),
   .rsp_last    (rsp_ch.last)
);

`default_nettype wire
